/* rtl/core/ia_fmt_pkg.sv */
package ia_fmt_pkg;

  // Conversion kinds carried in the func field.
  localparam logic [2:0] FUNC_SDEC  = 3'd0;
  localparam logic [2:0] FUNC_UDEC  = 3'd1;
  localparam logic [2:0] FUNC_HEXL  = 3'd2;
  localparam logic [2:0] FUNC_HEXU  = 3'd3;
  localparam logic [2:0] FUNC_PTR   = 3'd4;

  localparam logic [30:0] COUNT_MAX   = 31'h7FFF_FFFF;
  // Reciprocal of ten: floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_A_UPPER = 8'h41;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  func;
    logic        restart_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        last;
    logic [30:0] char_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIGIT,
    ST_PRE,
    ST_RD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic digit;
    logic emit_pre;
    logic rd;
    logic emit_dig;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic kind_ok;
    logic in_dec;
    logic is_dec;
    logic conv_done;
    logic pre_left;
    logic rd_last;
    logic out_free;
  } status_t;

  // Maps one digit to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = CH_A_UPPER + {4'd0, d - 4'd10};
    end else begin
      c = CH_A_LOWER + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

/* rtl/core/ia_fmt_ctrl.sv */
module ia_fmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ia_fmt_pkg::status_t st,
  output ia_fmt_pkg::cmd_t    cmd
);

  ia_fmt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ia_fmt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ia_fmt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.kind_ok) begin
            state_nxt = st.in_dec ? ia_fmt_pkg::ST_MUL : ia_fmt_pkg::ST_DIGIT;
          end
        end
      end
      ia_fmt_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ia_fmt_pkg::ST_DIGIT;
      end
      ia_fmt_pkg::ST_DIGIT: begin
        cmd.digit = 1'b1;
        if (st.conv_done) begin
          state_nxt = ia_fmt_pkg::ST_PRE;
        end else if (st.is_dec) begin
          state_nxt = ia_fmt_pkg::ST_MUL;
        end
      end
      ia_fmt_pkg::ST_PRE: begin
        if (!st.pre_left) begin
          state_nxt = ia_fmt_pkg::ST_RD;
        end else if (st.out_free) begin
          cmd.emit_pre = 1'b1;
        end
      end
      ia_fmt_pkg::ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ia_fmt_pkg::ST_OUT;
      end
      ia_fmt_pkg::ST_OUT: begin
        if (st.out_free) begin
          cmd.emit_dig = 1'b1;
          state_nxt    = st.rd_last ? ia_fmt_pkg::ST_IDLE : ia_fmt_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = ia_fmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/ia_fmt_dp.sv */
module ia_fmt_dp #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ia_fmt_pkg::in_word_t  in_data,
  output ia_fmt_pkg::out_word_t out_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ia_fmt_pkg::cmd_t      cmd,
  output ia_fmt_pkg::status_t   st
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int ND_W  = $clog2(MAX_DIGITS + 1);
  localparam logic [ND_W-1:0] ND_LAST = ND_W'(MAX_DIGITS - 1);

  logic [63:0]      work_r;
  logic [63:0]      prod_r;
  logic [ND_W-1:0]  nd_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [1:0]       npre_r;
  logic [1:0]       pre_idx_r;
  logic             dec_r;
  logic             upper_r;
  logic             ptr_r;
  logic [30:0]      count_r;
  logic [3:0]       rd_data_r;
  logic             out_valid_r;
  ia_fmt_pkg::out_word_t out_data_r;

  logic [3:0] mem [MAX_DIGITS];

  logic [28:0] quot;
  logic [3:0]  rem;
  logic [3:0]  digit;
  logic [63:0] work_next;
  logic [31:0] low;
  logic [30:0] count_inc;
  logic        load_out;
  logic        out_free;

  assign low       = in_data.value[31:0];
  assign quot      = prod_r[63:ia_fmt_pkg::RECIP_SHIFT];
  // Only the low nibble of x - 10*q is needed since the remainder is below ten.
  assign rem       = work_r[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
  assign digit     = dec_r ? rem : work_r[3:0];
  assign work_next = dec_r ? {35'd0, quot} : {4'd0, work_r[63:4]};
  assign count_inc = (count_r == ia_fmt_pkg::COUNT_MAX) ? count_r : count_r + 31'd1;
  assign out_free  = !out_valid_r || out_ready;
  assign load_out  = cmd.emit_pre || cmd.emit_dig;

  always_comb begin
    st           = '0;
    st.kind_ok   = (in_data.func <= ia_fmt_pkg::FUNC_PTR);
    st.in_dec    = (in_data.func == ia_fmt_pkg::FUNC_SDEC) ||
                   (in_data.func == ia_fmt_pkg::FUNC_UDEC);
    st.is_dec    = dec_r;
    st.conv_done = (work_next == 64'd0) || (nd_r == ND_LAST);
    st.pre_left  = (pre_idx_r != npre_r);
    st.rd_last   = (rd_idx_r == '0);
    st.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nd_r      <= '0;
      pre_idx_r <= 2'd0;
      dec_r     <= st.in_dec;
      upper_r   <= (in_data.func == ia_fmt_pkg::FUNC_HEXU);
      ptr_r     <= (in_data.func == ia_fmt_pkg::FUNC_PTR);
      unique case (in_data.func)
        ia_fmt_pkg::FUNC_SDEC: begin
          work_r <= {32'd0, low[31] ? (32'd0 - low) : low};
          npre_r <= {1'b0, low[31]};
        end
        ia_fmt_pkg::FUNC_PTR: begin
          work_r <= in_data.value;
          npre_r <= 2'd2;
        end
        default: begin
          work_r <= {32'd0, low};
          npre_r <= 2'd0;
        end
      endcase
    end
    if (cmd.mul) begin
      prod_r <= work_r[31:0] * ia_fmt_pkg::RECIP10;
    end
    if (cmd.digit) begin
      work_r   <= work_next;
      nd_r     <= nd_r + ND_W'(1);
      rd_idx_r <= nd_r[IDX_W-1:0];
    end
    if (cmd.emit_pre) begin
      pre_idx_r <= pre_idx_r + 2'd1;
    end
    if (cmd.emit_dig) begin
      rd_idx_r <= rd_idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit) begin
      mem[nd_r[IDX_W-1:0]] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_data.restart_count) begin
        count_r <= '0;
      end else if (load_out) begin
        count_r <= count_inc;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pre) begin
      out_data_r.char_code  <= !ptr_r ? ia_fmt_pkg::CH_MINUS :
                               (pre_idx_r == 2'd0) ? ia_fmt_pkg::CH_ZERO :
                               ia_fmt_pkg::CH_X_LOWER;
      out_data_r.last       <= 1'b0;
      out_data_r.char_count <= count_inc;
    end else if (cmd.emit_dig) begin
      out_data_r.char_code  <= ia_fmt_pkg::digit_char(rd_data_r, upper_r);
      out_data_r.last       <= (rd_idx_r == '0);
      out_data_r.char_count <= count_inc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/integer_to_ascii_formatter_core.sv */
// Integer-to-ASCII formatter in the style of the printf integer conversions.
// Each input word carries a number and a conversion kind (signed decimal with a
// leading minus, unsigned decimal, lower-case hex, upper-case hex, or a 64-bit
// pointer printed as "0x" plus lower-case hex), and the block returns the text
// one character per output word, most significant character first, with last
// set on the final character. Zero prints one '0' digit. Every output word
// also carries a running character count that saturates at 2147483647 and is
// cleared by restart_count before the word that sets it. Kinds 5 to 7 produce
// no output but still honor restart_count. The block works on one number at a
// time: in_ready is high only between numbers, although the last character of
// one number may still sit in the output register while the next is taken.
// Step by step: the number is accepted, then the digits are extracted, each
// decimal digit by a reciprocal multiply and then quotient and remainder, each
// hex digit directly; then the prefix characters are sent, and on the way out
// each digit is read back from the registered digit store before it is shown.
module integer_to_ascii_formatter_core #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ia_fmt_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ia_fmt_pkg::out_word_t out_data
);

  ia_fmt_pkg::cmd_t    cmd;
  ia_fmt_pkg::status_t st;

  // The controller sequences accept, extraction, prefix and readout.
  ia_fmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the working value, the digit store, the running count
  // and the output register.
  ia_fmt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* rtl/core/ia_fmt_checker.sv */
module ia_fmt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input ia_fmt_pkg::in_word_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input ia_fmt_pkg::out_word_t out_data
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // The count includes the character it travels with.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.char_count != 31'd0)
    else $error("character count of zero on a valid word");

  // A valid kind keeps the block busy after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func <= ia_fmt_pkg::FUNC_PTR) |=> !in_ready)
    else $error("input taken again right after a valid kind");

  // No new number is taken while one still has characters to come.
  a_no_accept_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |-> !in_ready)
    else $error("input ready before the last character");

endmodule

bind integer_to_ascii_formatter_core ia_fmt_checker u_ia_fmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/formatter_char_checker.sv */
module formatter_char_checker import ia_fmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        chars_pending,
  output int        words_taken,
  output int        chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Characters still owed by the block, oldest first.
  out_word_t expected_chars[$];
  logic [30:0] char_tally = '0;
  int n_fail = 0;
  int n_words = 0;
  int n_chars = 0;

  function automatic void queue_char(input logic [7:0] code, input logic is_last);
    out_word_t c;
    if (char_tally != COUNT_MAX) begin
      char_tally = char_tally + 31'd1;
    end
    c.char_code  = code;
    c.last       = is_last;
    c.char_count = char_tally;
    expected_chars.push_back(c);
  endfunction

  // Builds the text of one accepted number and queues its characters.
  function automatic void format_number(input in_word_t w);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [31:0] low;
    logic [3:0]  digs [16];
    logic [7:0]  pre [2];
    logic [7:0]  code;
    logic        upper;
    int          n_pre;
    int          n_dig;
    int          total;
    int          k;
    int          i;
    if (w.restart_count) begin
      char_tally = '0;
    end
    low   = w.value[31:0];
    mag   = {32'd0, low};
    radix = 64'd16;
    upper = 1'b0;
    n_pre = 0;
    case (w.func)
      FUNC_SDEC: begin
        radix = 64'd10;
        if (low[31]) begin
          pre[0] = CH_MINUS;
          n_pre  = 1;
          mag    = {32'd0, -low};
        end
      end
      FUNC_UDEC: begin
        radix = 64'd10;
      end
      FUNC_HEXL: begin
      end
      FUNC_HEXU: begin
        upper = 1'b1;
      end
      FUNC_PTR: begin
        pre[0] = CH_ZERO;
        pre[1] = CH_X_LOWER;
        n_pre  = 2;
        mag    = w.value;
      end
      default: begin
        return;
      end
    endcase
    n_dig = 0;
    do begin
      digs[n_dig] = 4'(mag % radix);
      mag = mag / radix;
      n_dig++;
    end while (mag != 0 && n_dig < 16);
    total = n_pre + n_dig;
    k = 0;
    for (i = 0; i < n_pre; i++) begin
      queue_char(pre[i], k == total - 1);
      k++;
    end
    for (i = n_dig - 1; i >= 0; i--) begin
      if (digs[i] < 4'd10) begin
        code = CH_ZERO + 8'(digs[i]);
      end else begin
        code = (upper ? CH_A_UPPER : CH_A_LOWER) + 8'(digs[i] - 4'd10);
      end
      queue_char(code, k == total - 1);
      k++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      expected_chars.delete();
      char_tally = '0;
    end else begin
      if (in_valid && in_ready) begin
        format_number(in_data);
        n_words++;
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("character 8'h%02h arrived with nothing expected", out_data.char_code);
          n_fail++;
        end else begin
          want = expected_chars.pop_front();
          n_chars++;
          if (out_data.char_code !== want.char_code) begin
            $error("char_code mismatch: expected 8'h%02h, got 8'h%02h",
                   want.char_code, out_data.char_code);
            n_fail++;
          end
          if (out_data.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, out_data.last);
            n_fail++;
          end
          if (out_data.char_count !== want.char_count) begin
            $error("char_count mismatch: expected %0d, got %0d",
                   want.char_count, out_data.char_count);
            n_fail++;
          end
        end
      end
    end
    // Published with nonblocking updates so the stimulus side always reads
    // the state as of the previous edge.
    fail_count    <= n_fail;
    chars_pending <= expected_chars.size();
    words_taken   <= n_words;
    chars_checked <= n_chars;
  end

endmodule

/* test/integer_to_ascii_formatter_core_test.sv */
module integer_to_ascii_formatter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ia_fmt_pkg::*;

  // Codes 5 to 7 of the func field select no conversion; the block must
  // swallow them silently apart from honoring restart_count.
  localparam logic [2:0] FUNC_RSVD5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  localparam int TARGET_WORDS = 450;
  // This tail outlasts a full pointer with the output always ready, so it
  // comfortably covers any trailing activity.
  localparam int TAIL_CYCLES  = 80;
  localparam int LONG_HOLD    = 400;
  // Worst case is roughly 450 words of 18 characters, each character stalled
  // by a receiver gap, plus sender gaps, well within this limit.
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count;
  int chars_pending;
  int words_taken;
  int chars_checked;

  // Phase controls shared between the sender and the receiver.
  logic hold_req = 1'b0;
  logic calm     = 1'b0;

  int cycles = 0;
  int words_sent = 0;
  int words_ignored = 0;
  int kind_count [5];

  integer_to_ascii_formatter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  formatter_char_checker char_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .words_taken   (words_taken),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle lengths shared by both sides: usually none or a short gap, now and
  // then a long one, so that stalls land on every phase of the block's digit
  // extraction and character output.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic in_word_t make_word(input logic [2:0] func, input logic [63:0] value,
                                         input logic restart);
    in_word_t w;
    w.value         = value;
    w.func          = func;
    w.restart_count = restart;
    return w;
  endfunction

  // Values that reach the interesting corners: full random patterns, tiny
  // numbers, single set or cleared bits, powers of ten and the values just
  // below them (both signs), and numbers of random length. Bar the one-bit
  // cases the upper half stays random to check that 32-bit kinds ignore it.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    logic [31:0] p;
    int k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: begin
      end
      1: v[31:0] = 32'($urandom_range(0, 99));
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~(64'd1 << $urandom_range(0, 63));
      4: begin
        k = $urandom_range(0, 9);
        p = 32'd1;
        repeat (k) p = p * 32'd10;
        p = p - 32'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) begin
          p = -p;
        end
        v[31:0] = p;
      end
      default: v = {v[63:32] >> $urandom_range(0, 32), v[31:0] >> $urandom_range(0, 31)};
    endcase
    return v;
  endfunction

  // Presents one word and holds it until the block takes it. Valid is left
  // high so that a following word can be offered back to back.
  task automatic send_word(input in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.func > FUNC_PTR) begin
      words_ignored++;
    end else begin
      words_sent++;
      kind_count[w.func]++;
    end
  endtask

  task automatic offer(input in_word_t w, input int gap);
    send_word(w);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender stops and waits until every queued character has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // Receiver: bursts of ready separated by random stalls, one very long
  // hold-off on request, and no stalls at all during the calm stretch.
  initial begin : receiver
    bit held;
    int gap;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= 1'b1;
      if (calm) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    in_word_t w;
    int r;
    int gap;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: each kind but upper-case hex at its extremes, the most
    // negative signed value, zero in every kind but upper-case hex, ignored upper
    // bits, and the unused kinds with and without a count restart.
    offer(make_word(FUNC_SDEC, 64'd0, 1'b0), pick_gap());
    offer(make_word(FUNC_SDEC, 64'hFFFF_FFFF_0000_0001, 1'b0), pick_gap());
    offer(make_word(FUNC_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0), pick_gap());
    offer(make_word(FUNC_SDEC, 64'h0000_0000_8000_0000, 1'b0), pick_gap());
    offer(make_word(FUNC_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0), pick_gap());
    offer(make_word(FUNC_UDEC, 64'd0, 1'b0), pick_gap());
    offer(make_word(FUNC_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0), pick_gap());
    offer(make_word(FUNC_UDEC, 64'd1000000000, 1'b0), pick_gap());
    offer(make_word(FUNC_UDEC, 64'hAAAA_AAAA_0000_0009, 1'b0), pick_gap());
    offer(make_word(FUNC_HEXL, 64'd0, 1'b0), pick_gap());
    offer(make_word(FUNC_HEXL, 64'h5555_5555_DEAD_BEEF, 1'b0), pick_gap());
    offer(make_word(FUNC_HEXL, 64'h0000_0000_FFFF_FFFF, 1'b0), pick_gap());
    offer(make_word(FUNC_HEXU, 64'h0000_0000_ABCD_EF01, 1'b0), pick_gap());
    offer(make_word(FUNC_HEXU, 64'h0000_0000_0000_000A, 1'b0), pick_gap());
    offer(make_word(FUNC_PTR, 64'd0, 1'b0), pick_gap());
    offer(make_word(FUNC_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0), pick_gap());
    offer(make_word(FUNC_PTR, 64'h0000_0001_0000_0000, 1'b0), pick_gap());
    offer(make_word(FUNC_PTR, 64'h8000_0000_0000_0000, 1'b0), pick_gap());
    offer(make_word(FUNC_PTR, 64'h0123_4567_89AB_CDEF, 1'b0), pick_gap());
    // An unused kind still clears the count, so the next word counts from one.
    offer(make_word(FUNC_RSVD5, 64'h1234_5678_9ABC_DEF0, 1'b1), pick_gap());
    offer(make_word(FUNC_UDEC, 64'd42, 1'b0), pick_gap());
    offer(make_word(FUNC_RSVD6, 64'd7, 1'b0), pick_gap());
    offer(make_word(FUNC_RSVD7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0), pick_gap());
    offer(make_word(FUNC_HEXU, 64'h0000_0000_0000_001F, 1'b1), pick_gap());
    offer(make_word(FUNC_SDEC, 64'h0000_0000_FFFF_FFF6, 1'b0), pick_gap());
    drain();

    // Random words. Along the way the receiver is asked for one long
    // hold-off while the sender keeps offering back to back, a stretch runs
    // with no idling on either side, and the sender once drains completely.
    while (words_sent < TARGET_WORDS) begin
      if (words_sent == 150 && !hold_req) begin
        hold_req <= 1'b1;
      end
      calm <= (words_sent >= 220 && words_sent < 280);
      if (words_sent == 320) begin
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 2))
          0: w.func = FUNC_RSVD5;
          1: w.func = FUNC_RSVD6;
          default: w.func = FUNC_RSVD7;
        endcase
      end else begin
        w.func = 3'($urandom_range(FUNC_SDEC, FUNC_PTR));
      end
      w.value = rand_value();
      w.restart_count = ($urandom_range(0, 19) == 0);
      gap = pick_gap();
      if ((words_sent >= 150 && words_sent < 176) || (words_sent >= 220 && words_sent < 280)) begin
        gap = 0;
      end
      offer(w, gap);
    end
    calm <= 1'b0;

    // Let every owed character arrive, then watch a while for strays.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers (signed %0d, unsigned %0d, hex %0d/%0d, pointer %0d)",
             words_sent, kind_count[FUNC_SDEC], kind_count[FUNC_UDEC],
             kind_count[FUNC_HEXL], kind_count[FUNC_HEXU], kind_count[FUNC_PTR]);
    $display("plus %0d words of unused kinds; %0d characters checked in %0d cycles",
             words_ignored, chars_checked, cycles);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
